/* rtl/rope_pkg.sv */
`timescale 1ns / 1ps

package rope_pkg;

  // Fixed sizes of the datapath
  localparam int unsigned ROM_DEPTH     = 64;
  localparam int unsigned CORDIC_STEPS  = 30;
  localparam int unsigned CW            = 34;
  localparam logic [63:0] INV_TWO_PI_Q32 = 64'h28BE_60DC;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  typedef struct packed {
    logic signed [15:0] x_first;
    logic signed [15:0] x_second;
    logic [5:0]         pair_index;
    logic [15:0]        token_index;
  } rope_in_t;

  typedef struct packed {
    logic signed [15:0] y_first;
    logic signed [15:0] y_second;
  } rope_out_t;

  // Data handed from one rotation cell to the next
  typedef struct packed {
    logic                 valid;
    logic signed [15:0]   x_first;
    logic signed [15:0]   x_second;
    quad_e                quad;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef logic [CORDIC_STEPS-1:0][31:0] atan_tab_t;

  // Floor square root, bit by bit
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'(1) << 62;
    for (int i = 0; i < 32; i++) begin
      if (b > v) b = b >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (b != '0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // Restoring division, used only while building constant tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-k in Q0.32 turns from the power series
  function automatic atan_tab_t build_atan();
    atan_tab_t   tab;
    logic [63:0] a;
    logic [63:0] term;
    tab[0] = 32'h2000_0000;
    for (int k = 1; k < CORDIC_STEPS; k++) begin
      a = '0;
      for (int j = 0; j < 31; j++) begin
        if (k * (2 * j + 1) <= 60) begin
          term = udiv64(64'(1) << (60 - k * (2 * j + 1)), 64'(2 * j + 1));
          if (j % 2 == 1) a = a - term;
          else a = a + term;
        end
      end
      tab[k] = 32'(((a >> 28) * INV_TWO_PI_Q32) >> 32);
    end
    return tab;
  endfunction

  // Start vector length: one over the accumulated rotation gain
  function automatic logic [63:0] build_start();
    logic [63:0] g;
    logic [63:0] s;
    g = 64'(1) << 30;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      s = g * g;
      s = s + (s >> (2 * k));
      g = isqrt64(s);
    end
    return udiv64(64'(1) << 60, g);
  endfunction

  localparam atan_tab_t            TURN_ATAN    = build_atan();
  localparam logic signed [CW-1:0] CORDIC_START = CW'(build_start());

endpackage

/* rtl/rope_phase.sv */
`timescale 1ns / 1ps

module rope_phase #(
  parameter int unsigned HEAD_SIZE  = 128,
  parameter int unsigned THETA_BASE = 10000,
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [19:0]        cfg_wdata_i,
  input  logic               item_valid_i,
  input  rope_pkg::rope_in_t item_i,
  output rope_pkg::cordic_t  cell_o
);
  import rope_pkg::*;

  localparam int unsigned PW = (PHASE_BITS < 32) ? PHASE_BITS : 32;

  typedef logic [ROM_DEPTH-1:0][31:0] rom_t;

  // Per-pair frequency in Q0.32 turns per position, integer arithmetic only
  function automatic rom_t build_rom();
    rom_t             rom;
    logic [63:0]      t;
    logic [63:0]      m;
    logic [63:0]      l;
    logic [63:0]      e;
    logic [63:0]      f;
    logic [63:0]      p;
    logic [63:0]      ip;
    logic [32:0][63:0] root;
    int unsigned      n;
    t = 64'(THETA_BASE);
    if (t < 64'd1) t = 64'd1;
    n = 0;
    for (int i = 0; i < 63; i++) begin
      if ((t >> (n + 1)) != '0) n = n + 1;
    end
    m = (n <= 31) ? (t << (31 - n)) : (t >> (n - 31));
    l = 64'(n) << 32;
    for (int k = 0; k < 32; k++) begin
      m = (m * m) >> 31;
      if (m >= (64'(1) << 32)) begin
        m = m >> 1;
        l = l | (64'(1) << (31 - k));
      end
    end
    root[0] = 64'(1) << 30;
    for (int k = 1; k <= 32; k++) begin
      root[k] = isqrt64(root[k-1] << 31);
    end
    for (int d = 0; d < ROM_DEPTH; d++) begin
      if (d >= HEAD_SIZE / 2) begin
        rom[d] = '0;
      end else begin
        e  = (l * 64'(2 * d)) / HEAD_SIZE;
        f  = e & 64'hFFFF_FFFF;
        ip = e >> 32;
        p  = 64'(1) << 31;
        for (int k = 1; k <= 32; k++) begin
          if (f[32-k]) p = (p * root[k]) >> 31;
        end
        p = (ip < 64'd63) ? (p >> ip) : '0;
        rom[d] = 32'((p * INV_TWO_PI_Q32 + (64'(1) << 30)) >> 31);
      end
    end
    return rom;
  endfunction

  localparam rom_t FREQ_ROM = build_rom();

  logic [19:0]        offset_q;
  logic               a_valid_q;
  logic [20:0]        a_pos_q;
  logic [31:0]        a_freq_q;
  logic signed [15:0] a_x1_q;
  logic signed [15:0] a_x2_q;
  logic               b_valid_q;
  logic [PW-1:0]      b_phase_q;
  logic signed [15:0] b_x1_q;
  logic signed [15:0] b_x2_q;
  logic [PW-1:0]      b_phase_d;
  logic               c_valid_q;
  cordic_t            cell_d;
  cordic_t            cell_q;

  // Hold the position offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // Advance the valid flags of the phase stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= item_valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // Stage A: position and frequency lookup
  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      a_pos_q  <= 21'(offset_q) + 21'(item_i.token_index);
      a_freq_q <= FREQ_ROM[item_i.pair_index];
      a_x1_q   <= item_i.x_first;
      a_x2_q   <= item_i.x_second;
    end
  end

  // Stage B: phase as the low turn bits of position times frequency
  always_comb begin
    logic [52:0] prod;
    prod      = a_pos_q * a_freq_q;
    b_phase_d = prod[31 -: PW];
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q) begin
      b_phase_q <= b_phase_d;
      b_x1_q    <= a_x1_q;
      b_x2_q    <= a_x2_q;
    end
  end

  // Stage C: split into nearest quarter turn and residue
  always_comb begin
    logic [31:0] phase;
    logic [32:0] rnd;
    logic [31:0] resid;
    phase         = 32'(b_phase_q) << (32 - PW);
    rnd           = 33'(phase) + 33'(32'h2000_0000);
    resid         = phase - {rnd[31:30], 30'b0};
    cell_d.valid  = b_valid_q;
    cell_d.x_first  = b_x1_q;
    cell_d.x_second = b_x2_q;
    cell_d.quad   = quad_e'(rnd[31:30]);
    cell_d.cx     = CORDIC_START;
    cell_d.cy     = '0;
    cell_d.z      = CW'($signed(resid));
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      cell_q <= cell_d;
    end
  end

  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = c_valid_q;
  end

  // Residue stays within an eighth of a turn
  a_resid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q |-> (cell_q.z >= -34'sd536870912) && (cell_q.z < 34'sd536870912))
    else $error("phase residue outside one eighth turn");

endmodule

/* rtl/rope_cordic_cell.sv */
`timescale 1ns / 1ps

module rope_cordic_cell #(
  parameter int unsigned SHIFT = 0,
  parameter logic [31:0] ATAN  = 32'h2000_0000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rope_pkg::cordic_t cell_i,
  output rope_pkg::cordic_t cell_o
);
  import rope_pkg::*;

  logic    valid_q;
  cordic_t data_d;
  cordic_t data_q;

  // Rotate toward zero residue by the arctangent of this cell
  always_comb begin
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    dx     = cell_i.cy >>> SHIFT;
    dy     = cell_i.cx >>> SHIFT;
    at     = $signed(CW'(ATAN));
    data_d = cell_i;
    if (!cell_i.z[CW-1]) begin
      data_d.cx = cell_i.cx - dx;
      data_d.cy = cell_i.cy + dy;
      data_d.z  = cell_i.z - at;
    end else begin
      data_d.cx = cell_i.cx + dx;
      data_d.cy = cell_i.cy - dy;
      data_d.z  = cell_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_i.valid) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

/* rtl/rope_rotate.sv */
`timescale 1ns / 1ps

module rope_rotate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rope_pkg::cordic_t   cell_i,
  output logic                done_o,
  output rope_pkg::rope_out_t out_o
);
  import rope_pkg::*;

  // Round half up by 15 bits and clamp to 16 signed bits
  function automatic logic signed [15:0] round_sat(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) return 16'sh7FFF;
    if (r < -34'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  logic               d_valid_q;
  logic signed [15:0] d_c_q;
  logic signed [15:0] d_s_q;
  logic signed [15:0] d_x1_q;
  logic signed [15:0] d_x2_q;
  logic signed [15:0] c_d;
  logic signed [15:0] s_d;
  logic               e_valid_q;
  logic signed [31:0] e_x1c_q;
  logic signed [31:0] e_x2s_q;
  logic signed [31:0] e_x2c_q;
  logic signed [31:0] e_x1s_q;
  logic               f_valid_q;
  rope_out_t          out_d;
  rope_out_t          out_q;

  // Stage D: undo the quarter turn and round to Q1.15
  always_comb begin
    logic signed [CW-1:0] c_full;
    logic signed [CW-1:0] s_full;
    case (cell_i.quad)
      QUAD_1: begin
        c_full = -cell_i.cy;
        s_full = cell_i.cx;
      end
      QUAD_2: begin
        c_full = -cell_i.cx;
        s_full = -cell_i.cy;
      end
      QUAD_3: begin
        c_full = cell_i.cy;
        s_full = -cell_i.cx;
      end
      default: begin
        c_full = cell_i.cx;
        s_full = cell_i.cy;
      end
    endcase
    c_d = round_sat(c_full);
    s_d = round_sat(s_full);
  end

  // Advance the valid flags of the output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      d_valid_q <= cell_i.valid;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_i.valid) begin
      d_c_q  <= c_d;
      d_s_q  <= s_d;
      d_x1_q <= cell_i.x_first;
      d_x2_q <= cell_i.x_second;
    end
  end

  // Stage E: the four products
  always_ff @(posedge clk_i) begin
    if (d_valid_q) begin
      e_x1c_q <= d_x1_q * d_c_q;
      e_x2s_q <= d_x2_q * d_s_q;
      e_x2c_q <= d_x2_q * d_c_q;
      e_x1s_q <= d_x1_q * d_s_q;
    end
  end

  // Stage F: combine, round and saturate
  always_comb begin
    out_d.y_first  = round_sat(CW'(e_x1c_q) - CW'(e_x2s_q));
    out_d.y_second = round_sat(CW'(e_x2c_q) + CW'(e_x1s_q));
  end

  always_ff @(posedge clk_i) begin
    if (e_valid_q) begin
      out_q <= out_d;
    end
  end

  assign done_o = f_valid_q;
  assign out_o  = out_q;

endmodule

/* rtl/rotary_position_embedding.sv */
`timescale 1ns / 1ps
// A result strobes on done_o for one cycle, once its start transaction reaches the stage F register.
// Throughput: one transaction per cycle; busy stays low, since the phase stages, the row of
// 30 rotation cells and the output stages all advance in every cycle and the receiver cannot stall.
// Reset: clears every stage valid flag and the position offset; the frequency table is constant.
module rotary_position_embedding #(
  parameter int unsigned HEAD_SIZE  = 128,
  parameter int unsigned THETA_BASE = 10000,
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rope_pkg::rope_in_t  in_i,
  output logic                done_o,
  output rope_pkg::rope_out_t out_o,
  input  logic                cfg_we_i,
  input  logic [19:0]         cfg_wdata_i
);
  import rope_pkg::*;

  localparam int unsigned LATENCY = CORDIC_STEPS + 6;

  logic    accept;
  cordic_t chain [CORDIC_STEPS+1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Position, frequency lookup and phase split
  rope_phase #(
    .HEAD_SIZE  (HEAD_SIZE),
    .THETA_BASE (THETA_BASE),
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (accept),
    .item_i       (in_i),
    .cell_o       (chain[0])
  );

  // Row of rotation cells, one step each
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    rope_cordic_cell #(
      .SHIFT (k),
      .ATAN  (TURN_ATAN[k])
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  // Quadrant fix, multiply and saturate
  rope_rotate u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cell_i (chain[CORDIC_STEPS]),
    .done_o (done_o),
    .out_o  (out_o)
  );

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("accepted transaction produced no result");

  a_result_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result without a matching transaction");

endmodule
